### rtl/core/nearest_palette_color_search_macros.svh
// Assertion macros used by the nearest palette color search checker.
`ifndef NEAREST_PALETTE_COLOR_SEARCH_MACROS_SVH
`define NEAREST_PALETTE_COLOR_SEARCH_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define NPCS_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define NPCS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### rtl/core/npcs_pkg.sv
// Package with shared types and constants of the nearest palette color search.
`default_nettype none
package npcs_pkg;

   localparam int CHAN_W     = 8;
   localparam int FIELD_IDX_W = 8;
   localparam int RSP_DIST_W = 10;
   localparam int DIST_W     = 14;
   localparam int STORE_DEPTH = 256;

   localparam logic [DIST_W-1:0] DIST_START = 14'd10000;

   localparam logic OP_WRITE  = 1'b0;
   localparam logic OP_LOOKUP = 1'b1;

   typedef struct packed {
      logic wr_en;
      logic start;
      logic rd_en;
      logic load_out;
   } cmd_type;

   typedef struct packed {
      logic last_addr;
      logic out_full;
   } status_type;

endpackage
`default_nettype wire

### rtl/core/npcs_ctrl.sv
// Controller state machine that sequences writes, palette scans and result hand-off.
`default_nettype none
module npcs_ctrl
   import npcs_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_tvalid,
   input  wire logic       req_op,
   output logic            req_tready,
   input  wire status_type status,
   output cmd_type         cmd
);

   typedef enum logic [1:0] {
      IDLE,
      SCAN,
      LAST,
      HOLD
   } state_type;

   state_type state_ff, state_in;
   logic      ready_ff, ready_in;
   logic      accept;

   assign accept     = req_tvalid && ready_ff;
   assign req_tready = ready_ff;

   always_comb begin
      cmd.wr_en    = accept && (req_op == OP_WRITE);
      cmd.start    = accept && (req_op == OP_LOOKUP);
      cmd.rd_en    = (state_ff == SCAN);
      cmd.load_out = (state_ff == HOLD) && !status.out_full;
   end

   always_comb begin
      state_in = state_ff;
      ready_in = ready_ff;
      case (state_ff)
         IDLE: begin
            if (cmd.start) begin
               state_in = SCAN;
               ready_in = 1'b0;
            end
         end
         SCAN: begin
            if (status.last_addr) begin
               state_in = LAST;
            end
         end
         LAST: begin
            state_in = HOLD;
         end
         HOLD: begin
            if (!status.out_full) begin
               state_in = IDLE;
               ready_in = 1'b1;
            end
         end
         default: begin
            state_in = IDLE;
            ready_in = 1'b1;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= IDLE;
         ready_ff <= 1'b1;
      end else begin
         state_ff <= state_in;
         ready_ff <= ready_in;
      end
   end

endmodule
`default_nettype wire

### rtl/core/npcs_dp.sv
// Datapath with the palette memory, scan counter, distance unit and result register.
`default_nettype none
module npcs_dp
   import npcs_pkg::*;
#(
   parameter int PALETTE_SIZE = 256
)
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic [FIELD_IDX_W-1:0] entry_index,
   input  wire logic [CHAN_W-1:0]      red,
   input  wire logic [CHAN_W-1:0]      green,
   input  wire logic [CHAN_W-1:0]      blue,
   input  wire cmd_type                cmd,
   output status_type                  status,
   input  wire logic                   rsp_tready,
   output logic                        rsp_valid,
   output logic [FIELD_IDX_W-1:0]      rsp_index,
   output logic [RSP_DIST_W-1:0]       rsp_distance
);

   localparam int IDX_W = (PALETTE_SIZE > 1) ? $clog2(PALETTE_SIZE) : 1;

   logic [3*CHAN_W-1:0] mem [PALETTE_SIZE];
   logic [PALETTE_SIZE-1:0] valid_ff;

   logic [IDX_W-1:0]     addr_ff;
   logic [3*CHAN_W-1:0]  rdata_ff;
   logic                 rvalid_ff;
   logic [IDX_W-1:0]     ridx_ff;
   logic                 cmp_en_ff;
   logic [CHAN_W-1:0]    q_red_ff, q_green_ff, q_blue_ff;
   logic [DIST_W-1:0]    best_d_ff;
   logic [IDX_W-1:0]     best_i_ff;
   logic                 rsp_valid_ff;
   logic [FIELD_IDX_W-1:0] rsp_index_ff;
   logic [RSP_DIST_W-1:0]  rsp_dist_ff;

   logic                 wr_in_range;
   logic [3*CHAN_W-1:0]  entry;
   logic [CHAN_W-1:0]    d_red, d_green, d_blue;
   logic [RSP_DIST_W-1:0] scan_dist;

   assign wr_in_range = ({1'b0, entry_index} < (FIELD_IDX_W + 1)'(PALETTE_SIZE));

   always_ff @(posedge clock) begin
      if (cmd.wr_en && wr_in_range) begin
         mem[entry_index[IDX_W-1:0]] <= {red, green, blue};
      end
      if (cmd.rd_en) begin
         rdata_ff <= mem[addr_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (cmd.wr_en && wr_in_range) begin
         valid_ff[entry_index[IDX_W-1:0]] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rd_en) begin
         rvalid_ff <= valid_ff[addr_ff];
         ridx_ff   <= addr_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cmp_en_ff <= 1'b0;
      end else begin
         cmp_en_ff <= cmd.rd_en;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.start) begin
         addr_ff <= '0;
      end else if (cmd.rd_en) begin
         addr_ff <= addr_ff + 1'b1;
      end
   end

   assign status.last_addr = (addr_ff == IDX_W'(PALETTE_SIZE - 1));

   assign entry = rvalid_ff ? rdata_ff : '0;

   always_comb begin
      logic [CHAN_W-1:0] e_red, e_green, e_blue;
      e_red   = entry[3*CHAN_W-1:2*CHAN_W];
      e_green = entry[2*CHAN_W-1:CHAN_W];
      e_blue  = entry[CHAN_W-1:0];
      d_red   = (q_red_ff   > e_red)   ? (q_red_ff   - e_red)   : (e_red   - q_red_ff);
      d_green = (q_green_ff > e_green) ? (q_green_ff - e_green) : (e_green - q_green_ff);
      d_blue  = (q_blue_ff  > e_blue)  ? (q_blue_ff  - e_blue)  : (e_blue  - q_blue_ff);
      scan_dist = RSP_DIST_W'(d_red) + RSP_DIST_W'(d_green) + RSP_DIST_W'(d_blue);
   end

   always_ff @(posedge clock) begin
      if (cmd.start) begin
         q_red_ff   <= red;
         q_green_ff <= green;
         q_blue_ff  <= blue;
         best_d_ff  <= DIST_START;
         best_i_ff  <= '0;
      end else if (cmp_en_ff && (DIST_W'(scan_dist) < best_d_ff)) begin
         best_d_ff <= DIST_W'(scan_dist);
         best_i_ff <= ridx_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.load_out) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_out) begin
         rsp_index_ff <= FIELD_IDX_W'(best_i_ff);
         rsp_dist_ff  <= best_d_ff[RSP_DIST_W-1:0];
      end
   end

   assign status.out_full = rsp_valid_ff && !rsp_tready;
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_index    = rsp_index_ff;
   assign rsp_distance = rsp_dist_ff;

endmodule
`default_nettype wire

### rtl/core/nearest_palette_color_search.sv
// A lookup result is loaded into the output register after the SCAN and LAST states, once
// HOLD finds the output free. A write item does not block the input; a lookup blocks it
// until its result is loaded, while the scan reads one palette entry per cycle through
// the single read port.
// A waiting result does not block writes; a new lookup waits only to hand off its result.
// Reset clears all palette valid bits, so every entry reads as zero, and empties the output.
`default_nettype none
module nearest_palette_color_search
   import npcs_pkg::*;
#(
   parameter int PALETTE_SIZE = 256
)
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [31:0] req_tdata,  // entry_index, red, green, blue
   input  wire logic        req_tuser,  // op
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [23:0]      rsp_tdata   // best_index, best_distance, zero fill
);

   cmd_type    cmd;
   status_type status;
   logic [FIELD_IDX_W-1:0] rsp_index;
   logic [RSP_DIST_W-1:0]  rsp_distance;

   npcs_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_op     (req_tuser),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   npcs_dp #(
      .PALETTE_SIZE (PALETTE_SIZE)
   ) u_dp (
      .clock        (clock),
      .reset        (reset),
      .entry_index  (req_tdata[7:0]),
      .red          (req_tdata[15:8]),
      .green        (req_tdata[23:16]),
      .blue         (req_tdata[31:24]),
      .cmd          (cmd),
      .status       (status),
      .rsp_tready   (rsp_tready),
      .rsp_valid    (rsp_tvalid),
      .rsp_index    (rsp_index),
      .rsp_distance (rsp_distance)
   );

   assign rsp_tdata = {6'b0, rsp_distance, rsp_index};

endmodule
`default_nettype wire

### rtl/core/npcs_checker.sv
// Port-level checker for the nearest palette color search and its bind statement.
`default_nettype none
`include "nearest_palette_color_search_macros.svh"
module npcs_checker #(
   parameter int PALETTE_SIZE = 256
)
(
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_tvalid,
   input wire logic        req_tready,
   input wire logic        req_tuser,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [23:0] rsp_tdata
);

   `NPCS_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata), "stalled result item changed")
   `NPCS_ASSERT_NOW(a_dist_range, clock, reset, rsp_tvalid, rsp_tdata[17:8] <= 10'd765, "result distance out of range")
   `NPCS_ASSERT_NOW(a_index_range, clock, reset, rsp_tvalid, {1'b0, rsp_tdata[7:0]} < 9'(PALETTE_SIZE), "result index outside palette")
   `NPCS_ASSERT_NEXT(a_lookup_busy, clock, reset, req_tvalid && req_tready && req_tuser, !req_tready, "input ready during palette scan")

endmodule

bind nearest_palette_color_search npcs_checker #(.PALETTE_SIZE(PALETTE_SIZE)) u_npcs_checker (.*);
`default_nettype wire

### sim/tb.sv
// Testbench for the nearest palette color search: random palette writes and checked lookups.
`timescale 1ns / 100ps

module tb;
   import npcs_pkg::*;

   localparam int PALETTE_ENTRIES = 256;
   localparam int RANDOM_ITEMS = 1030;

   typedef struct packed {
      logic [7:0] index;
      logic [9:0] distance;
   } nearest_type;

   typedef struct packed {
      logic       op;
      logic [7:0] slot;
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      bit         typed;
      logic [7:0] want_index;
      logic [9:0] want_dist;
   } plan_row_type;

   logic        clock = 1'b0;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [31:0] req_tdata;   // entry_index, red, green, blue
   logic        req_tuser;   // op
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [23:0] rsp_tdata;   // best_index, best_distance, zero fill

   logic        drive_typed;
   logic [7:0]  typed_index;
   logic [9:0]  typed_dist;

   logic [23:0] palette_shadow [STORE_DEPTH] = '{default: '0};
   nearest_type nearest_expected [$];

   bit calm_phase = 1'b0;
   int items_sent = 0;
   int writes_seen = 0;
   int lookups_seen = 0;
   int tie_lookups = 0;
   int exact_hits = 0;
   int results_checked = 0;
   int mismatches = 0;

   // Directed items: reset state, distance extremes, ties and alternating bit patterns.
   plan_row_type directed_plan [19] = '{
      '{OP_LOOKUP, 8'h00, 8'd0,   8'd0,   8'd0,   1'b1, 8'd0,   10'd0},
      '{OP_LOOKUP, 8'hFF, 8'd255, 8'd255, 8'd255, 1'b1, 8'd0,   10'd765},
      '{OP_LOOKUP, 8'h5A, 8'd1,   8'd2,   8'd3,   1'b1, 8'd0,   10'd6},
      '{OP_WRITE,  8'hFF, 8'd255, 8'd255, 8'd255, 1'b0, 8'd0,   10'd0},
      '{OP_LOOKUP, 8'h00, 8'd255, 8'd255, 8'd255, 1'b1, 8'd255, 10'd0},
      '{OP_LOOKUP, 8'h00, 8'd200, 8'd200, 8'd200, 1'b1, 8'd255, 10'd165},
      '{OP_WRITE,  8'h00, 8'd255, 8'd255, 8'd255, 1'b0, 8'd0,   10'd0},
      '{OP_LOOKUP, 8'hA5, 8'd255, 8'd255, 8'd255, 1'b1, 8'd0,   10'd0},
      '{OP_WRITE,  8'h80, 8'd10,  8'd20,  8'd30,  1'b0, 8'd0,   10'd0},
      '{OP_LOOKUP, 8'h00, 8'd10,  8'd20,  8'd30,  1'b1, 8'd128, 10'd0},
      '{OP_LOOKUP, 8'h00, 8'd0,   8'd0,   8'd0,   1'b1, 8'd1,   10'd0},
      '{OP_WRITE,  8'h01, 8'hAA,  8'h55,  8'hAA,  1'b0, 8'd0,   10'd0},
      '{OP_WRITE,  8'h02, 8'h55,  8'hAA,  8'h55,  1'b0, 8'd0,   10'd0},
      '{OP_LOOKUP, 8'h55, 8'hAA,  8'h55,  8'hAA,  1'b1, 8'd1,   10'd0},
      '{OP_LOOKUP, 8'hAA, 8'h55,  8'hAA,  8'h55,  1'b1, 8'd2,   10'd0},
      '{OP_LOOKUP, 8'h00, 8'd0,   8'd0,   8'd0,   1'b1, 8'd3,   10'd0},
      '{OP_LOOKUP, 8'h3C, 8'd128, 8'd64,  8'd32,  1'b0, 8'd0,   10'd0},
      '{OP_WRITE,  8'h7F, 8'd0,   8'd255, 8'd0,   1'b0, 8'd0,   10'd0},
      '{OP_LOOKUP, 8'hC3, 8'd0,   8'd250, 8'd0,   1'b0, 8'd0,   10'd0}
   };

   nearest_palette_color_search uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always #6 clock = ~clock;

   function automatic int chan_gap(input logic [7:0] a, input logic [7:0] b);
      return (a > b) ? int'(a) - int'(b) : int'(b) - int'(a);
   endfunction

   function automatic void predict_nearest(input logic [7:0] r, g, b,
                                           output nearest_type found);
      int best;
      int pick;
      int d;
      bit tied;
      logic [23:0] e;
      best = int'(DIST_START);
      pick = 0;
      tied = 1'b0;
      for (int i = 0; i < PALETTE_ENTRIES; i++) begin
         e = palette_shadow[i];
         d = chan_gap(r, e[23:16]) + chan_gap(g, e[15:8]) + chan_gap(b, e[7:0]);
         if (d < best) begin
            best = d;
            pick = i;
            tied = 1'b0;
         end else if (d == best) begin
            tied = 1'b1;
         end
      end
      if (tied) tie_lookups++;
      if (best == 0) exact_hits++;
      found.index = 8'(pick);
      found.distance = 10'(best);
   endfunction

   function automatic logic [7:0] nudge(input logic [7:0] c);
      int v;
      v = int'(c) + int'($urandom_range(0, 8)) - 4;
      if (v < 0) v = 0;
      if (v > 255) v = 255;
      return 8'(v);
   endfunction

   task automatic send_item(input logic op, input logic [7:0] slot, r, g, b,
                            input bit typed = 1'b0, input logic [7:0] want_index = '0,
                            input logic [9:0] want_dist = '0);
      int gap;
      int roll;
      roll = $urandom_range(0, 99);
      if (calm_phase || roll < 60) gap = 0;
      else if (roll < 92) gap = $urandom_range(1, 3);
      else gap = $urandom_range(8, 40);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= op;
      req_tdata <= {b, g, r, slot};
      drive_typed <= typed;
      typed_index <= want_index;
      typed_dist <= want_dist;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      items_sent++;
      @(negedge clock);
   endtask

   always @(posedge clock) begin
      nearest_type want;
      nearest_type found;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            if (nearest_expected.size() == 0) begin
               $error("result with no lookup pending: rsp_tdata=%h", rsp_tdata);
               mismatches++;
            end else begin
               want = nearest_expected.pop_front();
               results_checked++;
               if (rsp_tdata[7:0] !== want.index) begin
                  $error("best_index: expected %0d, got %0d", want.index, rsp_tdata[7:0]);
                  mismatches++;
               end
               if (rsp_tdata[17:8] !== want.distance) begin
                  $error("best_distance: expected %0d, got %0d", want.distance,
                         rsp_tdata[17:8]);
                  mismatches++;
               end
               if (rsp_tdata[23:18] !== 6'd0) begin
                  $error("rsp_tdata fill: expected 0, got %h", rsp_tdata[23:18]);
                  mismatches++;
               end
            end
         end
         if (req_tvalid && req_tready) begin
            if (req_tuser == OP_WRITE) begin
               writes_seen++;
               if (int'(req_tdata[7:0]) < PALETTE_ENTRIES)
                  palette_shadow[req_tdata[7:0]] =
                     {req_tdata[15:8], req_tdata[23:16], req_tdata[31:24]};
            end else begin
               lookups_seen++;
               predict_nearest(req_tdata[15:8], req_tdata[23:16], req_tdata[31:24], found);
               if (drive_typed) begin
                  found.index = typed_index;
                  found.distance = typed_dist;
               end
               nearest_expected.push_back(found);
            end
         end
      end
   end

   initial begin
      int run;
      int stall;
      int roll;
      rsp_tready = 1'b0;
      wait (reset === 1'b0);
      @(negedge clock);
      forever begin
         rsp_tready <= 1'b1;
         run = $urandom_range(1, 20);
         repeat (run) @(negedge clock);
         roll = $urandom_range(0, 99);
         if (calm_phase || roll < 50) stall = 0;
         else if (roll < 90) stall = $urandom_range(1, 4);
         else if (roll < 98) stall = $urandom_range(5, 40);
         else stall = $urandom_range(100, 400);
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
      end
   end

   initial begin
      #40_000_000;
      $display("end of test: mismatches");
      $finish;
   end

   initial begin
      int kind;
      int count;
      int pick;
      logic [23:0] group_color [6];
      logic [23:0] color;
      logic [23:0] query;
      logic [7:0] slot;

      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tuser = OP_WRITE;
      drive_typed = 1'b0;
      typed_index = '0;
      typed_dist = '0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (directed_plan[s])
         send_item(directed_plan[s].op, directed_plan[s].slot, directed_plan[s].red,
                   directed_plan[s].green, directed_plan[s].blue, directed_plan[s].typed,
                   directed_plan[s].want_index, directed_plan[s].want_dist);

      while (items_sent < $size(directed_plan) + RANDOM_ITEMS) begin
         kind = $urandom_range(0, 9);
         if (kind <= 5) begin
            count = $urandom_range(1, 6);
            for (int j = 0; j < count; j++) begin
               if (j > 0 && $urandom_range(0, 4) == 0)
                  color = group_color[$urandom_range(0, j - 1)];
               else
                  color = 24'($urandom);
               slot = $urandom_range(0, 1) ? 8'($urandom_range(0, 15)) : 8'($urandom);
               group_color[j] = color;
               send_item(OP_WRITE, slot, color[23:16], color[15:8], color[7:0]);
            end
            repeat ($urandom_range(1, 3)) begin
               pick = $urandom_range(0, 9);
               color = group_color[$urandom_range(0, count - 1)];
               if (pick < 4) query = color;
               else if (pick < 7)
                  query = {nudge(color[23:16]), nudge(color[15:8]), nudge(color[7:0])};
               else if (pick < 9) query = 24'($urandom);
               else query = {{8{1'($urandom)}}, {8{1'($urandom)}}, {8{1'($urandom)}}};
               send_item(OP_LOOKUP, 8'($urandom), query[23:16], query[15:8], query[7:0]);
            end
         end else if (kind <= 7) begin
            repeat ($urandom_range(1, 5)) begin
               query = 24'($urandom);
               send_item(1'($urandom), 8'($urandom), query[23:16], query[15:8], query[7:0]);
            end
         end else if (kind == 8) begin
            if ($urandom_range(0, 1)) query = 24'($urandom);
            else query = {{8{1'($urandom)}}, {8{1'($urandom)}}, {8{1'($urandom)}}};
            send_item(OP_LOOKUP, 8'($urandom), query[23:16], query[15:8], query[7:0]);
         end else begin
            calm_phase = ~calm_phase;
            repeat ($urandom_range(8, 20)) begin
               color = 24'($urandom);
               send_item(OP_WRITE, 8'($urandom), color[23:16], color[15:8], color[7:0]);
            end
         end
      end
      req_tvalid <= 1'b0;
      calm_phase = 1'b0;

      while (nearest_expected.size() != 0) @(posedge clock);
      repeat (PALETTE_ENTRIES + 40) @(posedge clock);

      $display("Sent %0d palette writes and %0d lookups; %0d lookups hit a tie at the best distance.",
               writes_seen, lookups_seen, tie_lookups);
      $display("Checked %0d results (%0d exact color hits) under random gaps and back-pressure.",
               results_checked, exact_hits);
      if (mismatches == 0 && nearest_expected.size() == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule
